// ===== rtl/core/fre_pkg.sv =====
// Shared types, constants and helpers for the frame rotation engine.
package fre_pkg;

   localparam int MAX_SIDE_DEF   = 256;
   localparam int MAX_PIXELS_DEF = 65536;

   localparam int COLOR_W     = 8;
   localparam int PIX_W       = 3 * COLOR_W;
   localparam int COORD_W     = 9;              // width of the size registers
   localparam int PROD_W      = 2 * COORD_W;    // rows times columns
   localparam int ADDR_FULL_W = PROD_W + 1;     // row * width + column
   localparam int MODE_W      = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = COORD_W;

   typedef enum logic [MODE_W-1:0] {
      MODE_NONE = 2'd0,
      MODE_CW90 = 2'd1,
      MODE_CCW90 = 2'd2,
      MODE_ROT180 = 2'd3
   } mode_type;

   localparam logic [CSR_IDX_W-1:0] CSR_ROTATE_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd2;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [COORD_W-1:0] SIDE_RESET = 9'd256;

   typedef struct packed {
      mode_type            mode;
      logic [COORD_W-1:0]  height;   // already clamped to 1..max side
      logic [COORD_W-1:0]  width;
   } cfg_type;

   typedef struct packed {
      logic                valid;
      logic                last;
      logic [COORD_W-1:0]  si;
      logic [COORD_W-1:0]  sj;
   } rd_req_type;

   typedef struct packed {
      logic                en;
      logic [PROD_W-1:0]   addr;
      logic [PIX_W-1:0]    data;
   } wr_req_type;

   // Zero acts as one, anything above the max side acts as the max side.
   function automatic logic [COORD_W-1:0] side_limit(input logic [COORD_W-1:0] v,
                                                     input int max_side);
      logic [COORD_W-1:0] res;
      res = v;
      if (v == '0) begin
         res = COORD_W'(1);
      end else if (32'(v) > max_side) begin
         res = COORD_W'(max_side);
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/frame_rotation_engine.sv =====
// Frame rotation engine top level: loads a frame, reads it back rotated.
//
// One word is taken on every clock (busy is always low). A load word writes the
// next raster pixel; a read word, once the frame is complete, gives one display
// pixel on rsp_valid, through the registered request stage of the sequencer
// and the registered read port of the pixel store (one write and one read
// port, MAX_PIXELS words of 24 bits). Read words before the frame is complete
// and all load words give no response. rsp_valid lasts one cycle and the
// receiver cannot stall it, so it must take every response when it comes.
// The store is not cleared after reset. Write the configuration only while idle.
module frame_rotation_engine #(
   parameter int MAX_SIDE   = fre_pkg::MAX_SIDE_DEF,
   parameter int MAX_PIXELS = fre_pkg::MAX_PIXELS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_op,
   input  logic [fre_pkg::COLOR_W-1:0]        req_red_in,
   input  logic [fre_pkg::COLOR_W-1:0]        req_green_in,
   input  logic [fre_pkg::COLOR_W-1:0]        req_blue_in,
   output logic                               rsp_valid,
   output logic [fre_pkg::COLOR_W-1:0]        rsp_red_out,
   output logic [fre_pkg::COLOR_W-1:0]        rsp_green_out,
   output logic [fre_pkg::COLOR_W-1:0]        rsp_blue_out,
   output logic                               rsp_frame_last,
   input  logic                               csr_we,
   input  logic [fre_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fre_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int CLW = fre_pkg::COLOR_W;

   fre_pkg::cfg_type          cfg;
   fre_pkg::rd_req_type       rd_req;
   fre_pkg::wr_req_type       wr_req;
   logic [fre_pkg::PIX_W-1:0] out_pix;

   assign busy = 1'b0;

   fre_csr #(
      .MAX_SIDE(MAX_SIDE)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   fre_seq #(
      .MAX_PIXELS(MAX_PIXELS)
   ) u_seq (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .accept (start && !busy),
      .op     (req_op),
      .pix    ({req_red_in, req_green_in, req_blue_in}),
      .rd_req (rd_req),
      .wr_req (wr_req)
   );

   fre_store #(
      .MAX_PIXELS(MAX_PIXELS)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .width     (cfg.width),
      .rd_req    (rd_req),
      .wr_req    (wr_req),
      .out_valid (rsp_valid),
      .out_last  (rsp_frame_last),
      .out_pix   (out_pix)
   );

   assign rsp_red_out   = out_pix[3*CLW-1:2*CLW];
   assign rsp_green_out = out_pix[2*CLW-1:CLW];
   assign rsp_blue_out  = out_pix[CLW-1:0];

endmodule

// ===== rtl/core/fre_csr.sv =====
// Configuration registers of the frame rotation engine.
module fre_csr #(
   parameter int MAX_SIDE = fre_pkg::MAX_SIDE_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [fre_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fre_pkg::CSR_DATA_W-1:0]     csr_data,
   output fre_pkg::cfg_type                   cfg
);

   fre_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            fre_pkg::CSR_ROTATE_MODE: begin
               cfg_in.mode = fre_pkg::mode_type'(csr_data[fre_pkg::MODE_W-1:0]);
            end
            fre_pkg::CSR_FRAME_HEIGHT: begin
               cfg_in.height = fre_pkg::side_limit(csr_data, MAX_SIDE);
            end
            fre_pkg::CSR_FRAME_WIDTH: begin
               cfg_in.width = fre_pkg::side_limit(csr_data, MAX_SIDE);
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode   <= fre_pkg::MODE_NONE;
         cfg_ff.height <= fre_pkg::side_limit(fre_pkg::SIDE_RESET, MAX_SIDE);
         cfg_ff.width  <= fre_pkg::side_limit(fre_pkg::SIDE_RESET, MAX_SIDE);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/fre_seq.sv =====
// Load and display counters; turns each word into a store write or a store read.
module fre_seq #(
   parameter int MAX_PIXELS = fre_pkg::MAX_PIXELS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  fre_pkg::cfg_type                  cfg,
   input  logic                              accept,
   input  logic                              op,
   input  logic [fre_pkg::PIX_W-1:0]         pix,
   output fre_pkg::rd_req_type               rd_req,
   output fre_pkg::wr_req_type               wr_req
);

   localparam int CW = fre_pkg::COORD_W;
   localparam int PW = fre_pkg::PROD_W;

   logic [PW-1:0] load_count_ff, load_count_in;
   logic [CW-1:0] row_ff, row_in, col_ff, col_in;
   logic          loaded_ff, loaded_in;
   fre_pkg::rd_req_type rd_ff, rd_in;
   fre_pkg::wr_req_type wr_ff, wr_in;

   logic [PW-1:0] total, count_inc;
   logic          full;
   logic [CW-1:0] rows, cols, rows_m1, cols_m1, r, c;
   logic          last, col_wrap;

   assign total     = PW'(cfg.height) * PW'(cfg.width);
   assign count_inc = load_count_ff + 1'b1;
   assign full      = loaded_ff || (load_count_ff >= total);

   always_comb begin
      if (cfg.mode == fre_pkg::MODE_CW90 || cfg.mode == fre_pkg::MODE_CCW90) begin
         rows = cfg.width;
         cols = cfg.height;
      end else begin
         rows = cfg.height;
         cols = cfg.width;
      end
   end

   assign rows_m1  = rows - 1'b1;
   assign cols_m1  = cols - 1'b1;
   // clamp covers a size change in the middle of a readout
   assign r        = (row_ff < rows) ? row_ff : rows_m1;
   assign c        = (col_ff < cols) ? col_ff : cols_m1;
   assign last     = (row_ff >= rows_m1) && (col_ff >= cols_m1);
   assign col_wrap = ({1'b0, col_ff} + 1'b1) >= {1'b0, cols};

   always_comb begin
      load_count_in = load_count_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      loaded_in     = loaded_ff;
      rd_in         = rd_ff;
      rd_in.valid   = 1'b0;
      wr_in         = wr_ff;
      wr_in.en      = 1'b0;

      case (cfg.mode)
         fre_pkg::MODE_CW90: begin
            rd_in.si = cfg.height - 1'b1 - c;
            rd_in.sj = r;
         end
         fre_pkg::MODE_CCW90: begin
            rd_in.si = c;
            rd_in.sj = cfg.width - 1'b1 - r;
         end
         fre_pkg::MODE_ROT180: begin
            rd_in.si = cfg.height - 1'b1 - r;
            rd_in.sj = cfg.width - 1'b1 - c;
         end
         default: begin
            rd_in.si = r;
            rd_in.sj = c;
         end
      endcase
      rd_in.last = last;

      if (accept) begin
         if (op == fre_pkg::OP_LOAD) begin
            if (full) begin
               loaded_in = 1'b1;
            end else begin
               wr_in.en      = (32'(load_count_ff) < MAX_PIXELS);
               wr_in.addr    = load_count_ff;
               wr_in.data    = pix;
               load_count_in = count_inc;
               loaded_in     = (count_inc >= total);
            end
         end else if (full) begin
            rd_in.valid = 1'b1;
            loaded_in   = 1'b1;
            if (last) begin
               load_count_in = '0;
               row_in        = '0;
               col_in        = '0;
               loaded_in     = 1'b0;
            end else if (col_wrap) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         loaded_ff     <= 1'b0;
         rd_ff.valid   <= 1'b0;
         wr_ff.en      <= 1'b0;
      end else begin
         load_count_ff <= load_count_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         loaded_ff     <= loaded_in;
         rd_ff         <= rd_in;
         wr_ff         <= wr_in;
      end
   end

   assign rd_req = rd_ff;
   assign wr_req = wr_ff;

endmodule

// ===== rtl/core/fre_store.sv =====
// Pixel store: address multiply, one write port, one registered read port.
module fre_store #(
   parameter int MAX_PIXELS = fre_pkg::MAX_PIXELS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [fre_pkg::COORD_W-1:0]       width,
   input  fre_pkg::rd_req_type               rd_req,
   input  fre_pkg::wr_req_type               wr_req,
   output logic                              out_valid,
   output logic                              out_last,
   output logic [fre_pkg::PIX_W-1:0]         out_pix
);

   localparam int ADDR_W = $clog2(MAX_PIXELS);
   localparam int AW     = fre_pkg::ADDR_FULL_W;

   logic [fre_pkg::PIX_W-1:0] mem [MAX_PIXELS];
   logic [fre_pkg::PIX_W-1:0] q_ff;
   logic                      valid_ff, last_ff, in_range_ff;
   logic [AW-1:0]             rd_addr;
   logic                      in_range;

   assign rd_addr  = AW'(rd_req.si) * AW'(width) + AW'(rd_req.sj);
   assign in_range = (32'(rd_addr) < MAX_PIXELS);

   // read sees the old word on a same-address write
   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         mem[ADDR_W'(wr_req.addr)] <= wr_req.data;
      end
      if (rd_req.valid) begin
         q_ff <= mem[ADDR_W'(rd_addr)];
      end
      last_ff     <= rd_req.last;
      in_range_ff <= in_range;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= rd_req.valid;
      end
   end

   assign out_valid = valid_ff;
   assign out_last  = last_ff;
   assign out_pix   = in_range_ff ? q_ff : '0;

endmodule
